// ===== rtl/length_prefixed_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// length_prefixed_deframer_assert.svh
// Assertion macros for the deframer; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define LPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define LPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared widths, header constants and the result beat type of the deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int TAG_W     = 32;
    localparam int MAXP_W    = 32;

    // both header fields are four bytes
    localparam int HDR_BYTES = 4;
    localparam int HDR_CNT_W = $clog2(HDR_BYTES);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);

    // result queue
    localparam int OQ_DEPTH  = 3;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [TAG_W-1:0]  packet_tag;
        logic              last_byte;
        logic              empty_packet;
        logic              oversize;
    } t_result;

endpackage

// ===== rtl/length_prefixed_deframer.sv =====
// Path: input register, lpd_core, then the result queue that drives the output channel.
// Throughput: one byte per cycle while o_stall is low; header and payload bytes alike.
// Input stall comes from the three-entry result queue and the byte in the input register.
// Reset (synchronous, active low) clears frame state and queue; max_payload goes to all ones.
// No clearing pass: the block accepts bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
// length_prefixed_deframer
// Deframes a byte stream of packets: 4-byte big-endian length, 4-byte
// big-endian id, then the payload. One result beat per payload byte, one
// beat for an empty packet, one flagged beat for an oversize packet.
// ----------------------------------------------------------------------------
module length_prefixed_deframer import lpd_pkg::*; #(
    parameter int LENGTH_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    // result output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [TAG_W-1:0]  o_packet_tag,
    output logic              o_last_byte,
    output logic              o_empty_packet,
    output logic              o_oversize,
    // max_payload register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MAXP_W-1:0] i_cfg_data
);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [MAXP_W-1:0] r_max_payload;

    logic                in_fire;
    logic                core_push;
    t_result             core_result;
    logic                q_valid;
    logic                q_pop;
    t_result             q_data;
    logic [OQ_CNT_W-1:0] q_count;
    logic [OQ_CNT_W:0]   q_claimed;

    // Space check: queued beats plus the byte still in the input register
    // must leave room for one more. Built from registers only, so stall never
    // waits on i_valid.
    assign q_claimed = {1'b0, q_count} + {{OQ_CNT_W{1'b0}}, r_in_valid};
    assign o_stall   = (q_claimed >= (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign in_fire   = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_max_payload <= '1;
        end else begin
            r_in_valid <= in_fire;
            if (i_cfg_valid) begin
                r_max_payload <= i_cfg_data;
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_data_byte;
        end
    end

    lpd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_push        (core_push),
        .o_result      (core_result)
    );

    // queue entries serve as the result register
    assign q_pop = q_valid && !i_stall;

    lpd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_push),
        .i_data  (core_result),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_valid        = q_valid;
    assign o_payload_byte = q_data.payload_byte;
    assign o_packet_tag   = q_data.packet_tag;
    assign o_last_byte    = q_data.last_byte;
    assign o_empty_packet = q_data.empty_packet;
    assign o_oversize     = q_data.oversize;

endmodule

// ===== rtl/lpd_core.sv =====
// ----------------------------------------------------------------------------
// lpd_core
// Frame state and per-byte result logic: header assembly, payload counting,
// empty and oversize detection.
// ----------------------------------------------------------------------------
module lpd_core import lpd_pkg::*; #(
    parameter int LENGTH_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [MAXP_W-1:0] i_max_payload,
    output logic              o_push,
    output t_result           o_result
);

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_TAG = 2'd1,
        PH_PAY = 2'd2
    } t_phase;

    t_phase                 r_phase,   n_phase;
    logic [HDR_CNT_W-1:0]   r_hdr_cnt, n_hdr_cnt;
    logic [LENGTH_BITS-1:0] r_len,     n_len;
    logic [TAG_W-1:0]       r_tag,     n_tag;
    logic [LENGTH_BITS-1:0] r_pay_cnt, n_pay_cnt;
    logic                   r_drop,    n_drop;

    logic                   hdr_done;
    logic [LENGTH_BITS-1:0] len_shift;
    logic [TAG_W-1:0]       tag_shift;
    logic [LENGTH_BITS-1:0] pay_inc;
    logic                   pay_last;

    assign hdr_done  = (r_hdr_cnt == HDR_LAST);
    assign len_shift = LENGTH_BITS'({r_len, i_byte});
    assign tag_shift = {r_tag[TAG_W-BYTE_W-1:0], i_byte};
    assign pay_inc   = r_pay_cnt + LENGTH_BITS'(1);
    assign pay_last  = (pay_inc == r_len);

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_len     = r_len;
        n_tag     = r_tag;
        n_pay_cnt = r_pay_cnt;
        n_drop    = r_drop;
        o_push    = 1'b0;
        o_result  = '0;
        if (i_valid) begin
            case (r_phase)
                PH_TAG: begin
                    n_tag     = tag_shift;
                    n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                    if (hdr_done) begin
                        n_hdr_cnt           = '0;
                        o_result.packet_tag = tag_shift;
                        o_result.last_byte  = 1'b1;
                        if (r_len == '0) begin
                            // zero length: one empty beat, new packet next
                            o_push                = 1'b1;
                            o_result.empty_packet = 1'b1;
                            n_phase               = PH_LEN;
                            n_tag                 = '0;
                            n_pay_cnt             = '0;
                            n_drop                = 1'b0;
                        end else begin
                            n_phase   = PH_PAY;
                            n_pay_cnt = '0;
                            if (MAXP_W'(r_len) > i_max_payload) begin
                                o_push            = 1'b1;
                                o_result.oversize = 1'b1;
                                n_drop            = 1'b1;
                            end else begin
                                n_drop = 1'b0;
                            end
                        end
                    end
                end
                PH_PAY: begin
                    n_pay_cnt = pay_inc;
                    if (!r_drop) begin
                        o_push                = 1'b1;
                        o_result.payload_byte = i_byte;
                        o_result.packet_tag   = r_tag;
                        o_result.last_byte    = pay_last;
                    end
                    if (pay_last) begin
                        n_phase   = PH_LEN;
                        n_hdr_cnt = '0;
                        n_len     = '0;
                        n_tag     = '0;
                        n_pay_cnt = '0;
                        n_drop    = 1'b0;
                    end
                end
                default: begin
                    // length header; the unused phase code lands here too
                    n_phase   = PH_LEN;
                    n_len     = len_shift;
                    n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                    if (hdr_done) begin
                        n_hdr_cnt = '0;
                        n_phase   = PH_TAG;
                        n_tag     = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN;
            r_hdr_cnt <= '0;
            r_len     <= '0;
            r_tag     <= '0;
            r_pay_cnt <= '0;
            r_drop    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_tag     <= n_tag;
            r_pay_cnt <= n_pay_cnt;
            r_drop    <= n_drop;
        end
    end

endmodule

// ===== rtl/lpd_outq.sv =====
// ----------------------------------------------------------------------------
// lpd_outq
// Small result queue; decouples the output stall from the input side.
// ----------------------------------------------------------------------------
`include "length_prefixed_deframer_assert.svh"

module lpd_outq import lpd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_result             i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output t_result             o_data,
    output logic [OQ_CNT_W-1:0] o_count
);

    localparam logic [OQ_CNT_W-1:0] CNT_FULL = OQ_CNT_W'(OQ_DEPTH);

    t_result               r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wr, n_wr;
    logic [OQ_PTR_W-1:0]   r_rd, n_rd;
    logic [OQ_CNT_W-1:0]   r_count, n_count;

    // assertion helpers
    logic                  push_only;
    logic [OQ_CNT_W-1:0]   cnt_inc;
    logic                  at_bound;

    function automatic logic [OQ_PTR_W-1:0] ptr_inc(input logic [OQ_PTR_W-1:0] p);
        logic [OQ_PTR_W-1:0] q;
        if (p == OQ_PTR_W'(OQ_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + OQ_PTR_W'(1);
        end
        return q;
    endfunction

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    always_comb begin
        n_wr    = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd    = i_pop  ? ptr_inc(r_rd) : r_rd;
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + OQ_CNT_W'(1);
            2'b01:   n_count = r_count - OQ_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign push_only = i_push && !i_pop;
    assign cnt_inc   = r_count + OQ_CNT_W'(1);
    assign at_bound  = (r_count == '0) || (r_count == CNT_FULL);

    `LPD_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> (r_count != CNT_FULL), "queue overflow")
    `LPD_ASSERT_ALWAYS(a_count_bound, i_clk, !i_rst_n || (r_count <= CNT_FULL), "bad count")
    `LPD_ASSERT(a_count_up, i_clk, i_rst_n, push_only |=> r_count == $past(cnt_inc), "count stuck")
    `LPD_ASSERT(a_ptr_match, i_clk, i_rst_n, (r_wr == r_rd) |-> at_bound, "pointer mismatch")

endmodule
